>>> rtl/sox_pkg.sv
package sox_pkg;

   localparam int NUM_SLOTS  = 256;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int ADDR_W     = 8;
   localparam int TRIG_STEPS = 16;
   localparam int STEP_W     = $clog2(TRIG_STEPS);
   localparam int DATA_W     = 32;
   localparam int KIND_W     = 2;
   localparam int OP_W       = 4;
   localparam int FAULT_W    = 2;
   localparam int CORD_W     = 36;
   localparam int Z_W        = 34;
   localparam int DIV_NUM_W  = 50;
   localparam int DIV_DEN_W  = 34;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXEC  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL    = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV    = 4'd3;
   localparam logic [OP_W-1:0] OP_REM    = 4'd4;
   localparam logic [OP_W-1:0] OP_FUNC   = 4'd5;
   localparam logic [OP_W-1:0] OP_NEG    = 4'd6;
   localparam logic [OP_W-1:0] OP_ASSIGN = 4'd7;
   localparam logic [OP_W-1:0] OP_MIN    = 4'd8;
   localparam logic [OP_W-1:0] OP_MAX    = 4'd9;

   localparam logic [ADDR_W-1:0] FN_SIN   = 8'd0;
   localparam logic [ADDR_W-1:0] FN_COS   = 8'd1;
   localparam logic [ADDR_W-1:0] FN_TAN   = 8'd2;
   localparam logic [ADDR_W-1:0] FN_SQSIN = 8'd3;
   localparam logic [ADDR_W-1:0] FN_SQCOS = 8'd4;
   localparam logic [ADDR_W-1:0] FN_DEG   = 8'd5;

   localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_DIVZ = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_BAD  = 2'd2;
   localparam logic [FAULT_W-1:0] FAULT_SAT  = 2'd3;

   localparam logic signed [DATA_W-1:0] TURN_PER_RAD   = 32'sd683565276;
   localparam logic signed [DATA_W-1:0] DEG_TO_RAD_Q32 = 32'sd74961321;
   localparam logic signed [CORD_W-1:0] CORDIC_GAIN    = 36'sd652032874;
   localparam logic signed [DATA_W-1:0] ONE_Q16        = 32'sd65536;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr_a;
      logic [SLOT_W-1:0] addr_b;
   } var_rd_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } var_wr_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quo;
      logic [DIV_DEN_W-1:0] rmd;
   } div_rsp_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [CORD_W-1:0] sin_q30;
      logic signed [CORD_W-1:0] cos_q30;
   } cord_rsp_type;

   // atan(2^-i) in 2^-32 turn units, evaluated at elaboration
   function automatic logic [DATA_W-1:0] atan_turn(input int unsigned i);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [63:0]  num;
      logic [63:0]  rem;
      logic [63:0]  prod;
      int unsigned  d;
      int unsigned  e;
      if (i == 0) begin
         return 32'h2000_0000;
      end
      r = '0;
      for (int k = 0; k < 32; k++) begin
         d = 2 * k + 1;
         e = i * d;
         if (e <= 62) begin
            num = (64'd1 << 62) >> e;
            t   = '0;
            rem = '0;
            for (int bt = 63; bt >= 0; bt--) begin
               rem = {rem[62:0], num[bt]};
               t   = t << 1;
               if (rem >= 64'(d)) begin
                  rem = rem - 64'(d);
                  t   = t | 64'd1;
               end
            end
            if (k % 2 == 1) begin
               r = r - t;
            end else begin
               r = r + t;
            end
         end
      end
      r    = r >> 30;
      prod = r * 64'd683565276 + (64'd1 << 31);
      return prod[63:32];
   endfunction

endpackage

>>> rtl/sox_var_file.sv
module sox_var_file (
   input  logic                       clock,
   input  logic                       reset,
   input  sox_pkg::var_rd_type        rd,
   input  sox_pkg::var_wr_type        wr,
   output logic signed [sox_pkg::DATA_W-1:0] rd_data_a,
   output logic signed [sox_pkg::DATA_W-1:0] rd_data_b
);
   import sox_pkg::*;

   logic [DATA_W-1:0]    slot_ram_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [DATA_W-1:0]    rd_a_ff;
   logic [DATA_W-1:0]    rd_b_ff;
   logic                 ok_a_ff;
   logic                 ok_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_ram_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_a_ff <= slot_ram_ff[rd.addr_a];
         rd_b_ff <= slot_ram_ff[rd.addr_b];
      end
   end

   // slot never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ok_a_ff  <= 1'b0;
         ok_b_ff  <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            ok_a_ff <= valid_ff[rd.addr_a];
            ok_b_ff <= valid_ff[rd.addr_b];
         end
      end
   end

   assign rd_data_a = ok_a_ff ? signed'(rd_a_ff) : '0;
   assign rd_data_b = ok_b_ff ? signed'(rd_b_ff) : '0;

endmodule

>>> rtl/sox_divider.sv
module sox_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  sox_pkg::div_req_type req,
   output sox_pkg::div_rsp_type rsp
);
   import sox_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] rmd_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   assign trial = {rmd_ff, quo_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quo_ff  <= req.num;
            rmd_ff  <= '0;
            den_ff  <= req.den;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
            rmd_ff <= fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rmd  = rmd_ff;

endmodule

>>> rtl/sox_cordic.sv
module sox_cordic (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sox_pkg::DATA_W-1:0] phase,
   output sox_pkg::cord_rsp_type      rsp
);
   import sox_pkg::*;

   logic [DATA_W-1:0]        atan_rom [TRIG_STEPS];
   logic                     busy_ff;
   logic                     done_ff;
   logic                     flip_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [CORD_W-1:0] x_ff;
   logic signed [CORD_W-1:0] y_ff;
   logic signed [Z_W-1:0]    z_ff;
   logic signed [CORD_W-1:0] dx;
   logic signed [CORD_W-1:0] dy;
   logic signed [Z_W-1:0]    da;
   logic [DATA_W-1:0]        ph_quad;
   logic [DATA_W-1:0]        ph_turn;
   logic                     flip;

   for (genvar gi = 0; gi < TRIG_STEPS; gi++) begin : g_atan
      assign atan_rom[gi] = atan_turn(gi);
   end

   // second and third quadrant rotate by half a turn
   assign ph_quad = phase + 32'h4000_0000;
   assign flip    = ph_quad[DATA_W-1];
   assign ph_turn = flip ? phase + 32'h8000_0000 : phase;

   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign da = signed'(Z_W'(atan_rom[step_ff]));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            flip_ff <= flip;
            x_ff    <= CORDIC_GAIN;
            y_ff    <= '0;
            z_ff    <= Z_W'(signed'(ph_turn));
         end else if (busy_ff) begin
            if (!z_ff[Z_W-1]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - da;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + da;
            end
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(TRIG_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.busy    = busy_ff;
   assign rsp.done    = done_ff;
   assign rsp.sin_q30 = flip_ff ? -y_ff : y_ff;
   assign rsp.cos_q30 = flip_ff ? -x_ff : x_ff;

endmodule

>>> rtl/scalar_op_executor_unit.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   kind, opcode, src_a, src_b, dest, value
// rsp       out        rsp_valid/rsp_stall   result, fault
//
// one transaction at a time: read, write and simple ops finish from the exec state, mul,
// square waves and degrees pass through the mul state, sine and cosine wait on the cordic
// (TRIG_STEPS cordic steps), div and rem on the 50-step divider, tangent on cordic then divider
// reset clears every slot to zero through per-slot valid bits, no sweep
// a held result in the rsp register does not block the next transaction;
// only its completion waits for the register to free up
module scalar_op_executor_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sox_pkg::KIND_W-1:0]          req_kind,
   input  logic [sox_pkg::OP_W-1:0]            req_opcode,
   input  logic [sox_pkg::ADDR_W-1:0]          req_src_a,
   input  logic [sox_pkg::ADDR_W-1:0]          req_src_b,
   input  logic [sox_pkg::ADDR_W-1:0]          req_dest,
   input  logic signed [sox_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sox_pkg::DATA_W-1:0]   rsp_result,
   output logic [sox_pkg::FAULT_W-1:0]         rsp_fault
);
   import sox_pkg::*;

   localparam int SAT_W = 50;
   localparam int PROD_W = 2 * DATA_W;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_MUL, S_CORD, S_DIV, S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [KIND_W-1:0]         kind_ff, kind_in;
   logic [OP_W-1:0]           op_ff, op_in;
   logic [ADDR_W-1:0]         fn_ff, fn_in;
   logic [SLOT_W-1:0]         dest_ff, dest_in;
   logic signed [DATA_W-1:0]  value_ff, value_in;
   logic                      a_rng_ff, a_rng_in;
   logic                      b_rng_ff, b_rng_in;
   logic                      dest_rng_ff, dest_rng_in;
   logic signed [DATA_W-1:0]  res_ff, res_in;
   logic [FAULT_W-1:0]        fault_ff, fault_in;
   logic                      wr_ok_ff, wr_ok_in;
   logic                      neg_ff, neg_in;
   logic                      is_rem_ff, is_rem_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_result_ff, rsp_result_in;
   logic [FAULT_W-1:0]        rsp_fault_ff, rsp_fault_in;

   var_rd_type                var_rd;
   var_wr_type                var_wr;
   div_req_type               div_req;
   div_rsp_type               div_rsp;
   cord_rsp_type              cord_rsp;
   logic                      cord_start;
   logic signed [DATA_W-1:0]  rd_data_a, rd_data_b;
   logic signed [DATA_W-1:0]  a_val, b_val;
   logic [DATA_W-1:0]         a_mag, b_mag;
   logic signed [DATA_W-1:0]  mul_x, mul_y;
   logic signed [SAT_W-1:0]   sum_w, diff_w, neg_w, mul_w;
   logic signed [PROD_W-1:0]  deg_sum;
   logic [DATA_W-1:0]         ph;
   logic [CORD_W-1:0]         s_mag, c_mag;
   logic                      out_free;
   logic                      quo_ovf;

   function automatic logic sat_ovf(input logic signed [SAT_W-1:0] v);
      return (v > SAT_W'(64'sh7FFF_FFFF)) || (v < -SAT_W'(64'sh8000_0000));
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_val(input logic signed [SAT_W-1:0] v);
      if (v > SAT_W'(64'sh7FFF_FFFF)) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -SAT_W'(64'sh8000_0000)) begin
         return 32'sh8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] q30_to_q16(input logic signed [CORD_W-1:0] v);
      logic signed [CORD_W:0] t;
      t = (CORD_W+1)'(v) + (CORD_W+1)'(8192);
      return DATA_W'(t >>> 14);
   endfunction

   sox_var_file u_var_file (
      .clock     (clock),
      .reset     (reset),
      .rd        (var_rd),
      .wr        (var_wr),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   sox_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   sox_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .phase (ph),
      .rsp   (cord_rsp)
   );

   assign a_val = a_rng_ff ? rd_data_a : '0;
   assign b_val = b_rng_ff ? rd_data_b : '0;
   assign a_mag = a_val[DATA_W-1] ? DATA_W'(-a_val) : DATA_W'(a_val);
   assign b_mag = b_val[DATA_W-1] ? DATA_W'(-b_val) : DATA_W'(b_val);

   assign sum_w  = SAT_W'(a_val) + SAT_W'(b_val);
   assign diff_w = SAT_W'(a_val) - SAT_W'(b_val);
   assign neg_w  = -SAT_W'(a_val);
   assign mul_w  = SAT_W'(prod_ff >>> 16);

   always_comb begin
      if (op_ff == OP_FUNC) begin
         mul_x = b_val;
         mul_y = (fn_ff == FN_DEG) ? DEG_TO_RAD_Q32 : TURN_PER_RAD;
      end else begin
         mul_x = a_val;
         mul_y = b_val;
      end
   end

   assign prod_in = mul_x * mul_y;
   assign deg_sum = prod_ff + PROD_W'(64'sh8000_0000);
   assign ph      = prod_ff[47:16];

   assign s_mag = cord_rsp.sin_q30[CORD_W-1] ? CORD_W'(-cord_rsp.sin_q30)
                                             : CORD_W'(cord_rsp.sin_q30);
   assign c_mag = cord_rsp.cos_q30[CORD_W-1] ? CORD_W'(-cord_rsp.cos_q30)
                                             : CORD_W'(cord_rsp.cos_q30);

   assign quo_ovf = neg_ff ? (div_rsp.quo > DIV_NUM_W'(64'h8000_0000))
                           : (div_rsp.quo > DIV_NUM_W'(64'h7FFF_FFFF));

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      op_in         = op_ff;
      fn_in         = fn_ff;
      dest_in       = dest_ff;
      value_in      = value_ff;
      a_rng_in      = a_rng_ff;
      b_rng_in      = b_rng_ff;
      dest_rng_in   = dest_rng_ff;
      res_in        = res_ff;
      fault_in      = fault_ff;
      wr_ok_in      = wr_ok_ff;
      neg_in        = neg_ff;
      is_rem_in     = is_rem_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      rsp_fault_in  = rsp_fault_ff;

      var_rd.en     = 1'b0;
      var_rd.addr_a = req_src_a[SLOT_W-1:0];
      var_rd.addr_b = req_src_b[SLOT_W-1:0];
      var_wr.en     = 1'b0;
      var_wr.addr   = dest_ff;
      var_wr.data   = res_ff;
      div_req.start = 1'b0;
      div_req.num   = {2'b00, a_mag, 16'h0000};
      div_req.den   = {2'b00, b_mag};
      cord_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               var_rd.en   = 1'b1;
               kind_in     = req_kind;
               op_in       = req_opcode;
               fn_in       = req_src_a;
               dest_in     = req_dest[SLOT_W-1:0];
               value_in    = req_value;
               a_rng_in    = {1'b0, req_src_a} < 9'(NUM_SLOTS);
               b_rng_in    = {1'b0, req_src_b} < 9'(NUM_SLOTS);
               dest_rng_in = {1'b0, req_dest} < 9'(NUM_SLOTS);
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            wr_ok_in = 1'b0;
            fault_in = FAULT_NONE;
            res_in   = '0;
            unique case (kind_ff)
               KIND_WRITE: begin
                  res_in   = value_ff;
                  wr_ok_in = 1'b1;
               end
               KIND_READ: begin
                  res_in = a_val;
               end
               KIND_EXEC: begin
                  wr_ok_in = 1'b1;
                  unique case (op_ff)
                     OP_ADD: begin
                        res_in   = sat_val(sum_w);
                        fault_in = sat_ovf(sum_w) ? FAULT_SAT : FAULT_NONE;
                     end
                     OP_SUB: begin
                        res_in   = sat_val(diff_w);
                        fault_in = sat_ovf(diff_w) ? FAULT_SAT : FAULT_NONE;
                     end
                     OP_NEG: begin
                        res_in   = sat_val(neg_w);
                        fault_in = sat_ovf(neg_w) ? FAULT_SAT : FAULT_NONE;
                     end
                     OP_ASSIGN: res_in = a_val;
                     OP_MIN:    res_in = (a_val < b_val) ? a_val : b_val;
                     OP_MAX:    res_in = (a_val > b_val) ? a_val : b_val;
                     OP_MUL:    state_in = S_MUL;
                     OP_DIV, OP_REM: begin
                        if (b_val == '0) begin
                           fault_in = FAULT_DIVZ;
                        end else begin
                           div_req.start = 1'b1;
                           is_rem_in     = (op_ff == OP_REM);
                           if (op_ff == OP_REM) begin
                              div_req.num = {18'h0, a_mag};
                              neg_in      = a_val[DATA_W-1];
                           end else begin
                              neg_in = a_val[DATA_W-1] ^ b_val[DATA_W-1];
                           end
                           state_in = S_DIV;
                        end
                     end
                     OP_FUNC: begin
                        if (fn_ff > FN_DEG) begin
                           wr_ok_in = 1'b0;
                           fault_in = FAULT_BAD;
                        end else begin
                           state_in = S_MUL;
                        end
                     end
                     default: begin
                        wr_ok_in = 1'b0;
                        fault_in = FAULT_BAD;
                     end
                  endcase
               end
               default: begin
                  fault_in = FAULT_BAD;
               end
            endcase
         end
         S_MUL: begin
            state_in = S_DONE;
            if (op_ff == OP_MUL) begin
               res_in   = sat_val(mul_w);
               fault_in = sat_ovf(mul_w) ? FAULT_SAT : FAULT_NONE;
            end else begin
               unique case (fn_ff)
                  FN_SIN, FN_COS, FN_TAN: begin
                     cord_start = 1'b1;
                     state_in   = S_CORD;
                  end
                  FN_SQSIN: res_in = ph[DATA_W-1] ? -ONE_Q16 : ONE_Q16;
                  FN_SQCOS: begin
                     res_in = (ph <= 32'h4000_0000 || ph >= 32'hC000_0000) ? ONE_Q16
                                                                          : -ONE_Q16;
                  end
                  FN_DEG:   res_in = deg_sum[PROD_W-1:DATA_W];
                  default:  res_in = '0;
               endcase
            end
         end
         S_CORD: begin
            if (cord_rsp.done) begin
               state_in = S_DONE;
               unique case (fn_ff)
                  FN_SIN: res_in = q30_to_q16(cord_rsp.sin_q30);
                  FN_COS: res_in = q30_to_q16(cord_rsp.cos_q30);
                  default: begin
                     if (cord_rsp.cos_q30 == '0) begin
                        fault_in = FAULT_SAT;
                        res_in   = cord_rsp.sin_q30[CORD_W-1] ? 32'sh8000_0000
                                                              : 32'sh7FFF_FFFF;
                     end else begin
                        div_req.start = 1'b1;
                        div_req.num   = {s_mag[DIV_DEN_W-1:0], 16'h0000};
                        div_req.den   = c_mag[DIV_DEN_W-1:0];
                        neg_in        = cord_rsp.sin_q30[CORD_W-1] ^
                                        cord_rsp.cos_q30[CORD_W-1];
                        is_rem_in     = 1'b0;
                        state_in      = S_DIV;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_DONE;
               if (is_rem_ff) begin
                  res_in = neg_ff ? -signed'(DATA_W'(div_rsp.rmd))
                                  : signed'(DATA_W'(div_rsp.rmd));
               end else if (quo_ovf) begin
                  fault_in = FAULT_SAT;
                  res_in   = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end else begin
                  res_in = neg_ff ? -signed'(DATA_W'(div_rsp.quo))
                                  : signed'(DATA_W'(div_rsp.quo));
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               var_wr.en     = wr_ok_ff && dest_rng_ff;
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               rsp_fault_in  = fault_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      op_ff         <= op_in;
      fn_ff         <= fn_in;
      dest_ff       <= dest_in;
      value_ff      <= value_in;
      a_rng_ff      <= a_rng_in;
      b_rng_ff      <= b_rng_in;
      dest_rng_ff   <= dest_rng_in;
      res_ff        <= res_in;
      fault_ff      <= fault_in;
      wr_ok_ff      <= wr_ok_in;
      neg_ff        <= neg_in;
      is_rem_ff     <= is_rem_in;
      prod_ff       <= prod_in;
      rsp_result_ff <= rsp_result_in;
      rsp_fault_ff  <= rsp_fault_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_fault  = rsp_fault_ff;

`ifndef SYNTHESIS
   a_wr_only_done: assert property (@(posedge clock) disable iff (reset)
      var_wr.en |-> (state_ff == S_DONE && out_free))
      else $error("slot write outside completion");
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");
   a_cord_done_wait: assert property (@(posedge clock) disable iff (reset)
      cord_rsp.done |-> state_ff == S_CORD)
      else $error("cordic finished with no waiting op");
   a_rd_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> var_rd.en)
      else $error("transaction accepted without operand read");
`endif

endmodule

>>> tb/scalar_op_executor_unit_tb.sv
module scalar_op_executor_unit_tb;
   import sox_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] result;
      logic [FAULT_W-1:0]       fault;
   } rsp_item_type;

   localparam longint TURN_RAD   = 64'sd683565276;
   localparam longint GAIN_Q30   = 64'sd652032874;
   localparam longint DEG_RAD    = 64'sd74961321;
   localparam longint MAX32      = 64'sd2147483647;
   localparam longint MIN32      = -64'sd2147483648;
   localparam logic [DATA_W-1:0] MAXV = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] MINV = 32'h8000_0000;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [KIND_W-1:0]          req_kind;
   logic [OP_W-1:0]            req_opcode;
   logic [ADDR_W-1:0]          req_src_a;
   logic [ADDR_W-1:0]          req_src_b;
   logic [ADDR_W-1:0]          req_dest;
   logic signed [DATA_W-1:0]   req_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [DATA_W-1:0]   rsp_result;
   logic [FAULT_W-1:0]         rsp_fault;

   logic signed [DATA_W-1:0]   slot_mirror [NUM_SLOTS];
   longint                     atan_tbl [TRIG_STEPS];
   rsp_item_type               expected_rsps [$];
   int                         err_count;
   int                         send_idle_pct;
   int                         rsp_stall_pct;

   scalar_op_executor_unit uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint arctan_turns(input int unsigned i);
      longint r;
      longint t;
      r = 0;
      if (i == 0) return 64'sd1 <<< 29;
      for (int unsigned k = 0; i * (2 * k + 1) <= 62; k++) begin
         t = longint'((64'd1 << 62) >> (i * (2 * k + 1))) / longint'(2 * k + 1);
         if (k % 2 == 1) r = r - t;
         else r = r + t;
      end
      r = r >>> 30;
      return (r * TURN_RAD + (64'sd1 <<< 31)) >>> 32;
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp32(input longint v,
                                                        inout logic [FAULT_W-1:0] f);
      if (v > MAX32) begin
         f = FAULT_SAT;
         return MAXV;
      end
      if (v < MIN32) begin
         f = FAULT_SAT;
         return MINV;
      end
      return v[31:0];
   endfunction

   function automatic void rotate(input logic [31:0] ph, output longint s, output longint c);
      logic [31:0] q;
      logic        flip;
      longint      x, y, z, dx, dy;
      q = ph + 32'h4000_0000;
      flip = q[31];
      if (flip) ph = ph + 32'h8000_0000;
      z = longint'($signed(ph));
      x = GAIN_Q30;
      y = 0;
      for (int i = 0; i < TRIG_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_tbl[i];
         end else begin
            x = x + dx; y = y - dy; z = z + atan_tbl[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      s = y;
      c = x;
   endfunction

   function automatic rsp_item_type execute_model(input logic [KIND_W-1:0] kind,
                                                  input logic [OP_W-1:0] op,
                                                  input logic [ADDR_W-1:0] sa,
                                                  input logic [ADDR_W-1:0] sb,
                                                  input logic [ADDR_W-1:0] dst,
                                                  input logic signed [DATA_W-1:0] val);
      rsp_item_type r;
      longint      a, b, p, s, c, t;
      logic [31:0] ph;
      logic        ok;
      r.result = '0;
      r.fault  = FAULT_NONE;
      ok = 1'b1;
      if (kind == KIND_WRITE) begin
         r.result = val;
         slot_mirror[dst] = val;
      end else if (kind == KIND_READ) begin
         r.result = slot_mirror[sa];
      end else if (kind == KIND_EXEC) begin
         a = slot_mirror[sa];
         b = slot_mirror[sb];
         case (op)
            OP_ADD: r.result = clamp32(a + b, r.fault);
            OP_SUB: r.result = clamp32(a - b, r.fault);
            OP_MUL: r.result = clamp32((a * b) >>> 16, r.fault);
            OP_DIV: begin
               if (b == 0) r.fault = FAULT_DIVZ;
               else r.result = clamp32((a * 65536) / b, r.fault);
            end
            OP_REM: begin
               if (b == 0) r.fault = FAULT_DIVZ;
               else begin
                  t = a % b;
                  r.result = t[31:0];
               end
            end
            OP_FUNC: begin
               p = b * TURN_RAD;
               ph = p[47:16];
               case (sa)
                  FN_SIN, FN_COS, FN_TAN: begin
                     rotate(ph, s, c);
                     if (sa == FN_SIN) begin
                        t = (s + 8192) >>> 14;
                        r.result = t[31:0];
                     end else if (sa == FN_COS) begin
                        t = (c + 8192) >>> 14;
                        r.result = t[31:0];
                     end else if (c == 0) begin
                        r.fault = FAULT_SAT;
                        r.result = (s >= 0) ? MAXV : MINV;
                     end else begin
                        r.result = clamp32((s * 65536) / c, r.fault);
                     end
                  end
                  FN_SQSIN: r.result = ph[31] ? -ONE_Q16 : ONE_Q16;
                  FN_SQCOS: r.result = (ph <= 32'h4000_0000 || ph >= 32'hc000_0000) ?
                                       ONE_Q16 : -ONE_Q16;
                  FN_DEG: begin
                     t = (b * DEG_RAD + (64'sd1 <<< 31)) >>> 32;
                     r.result = t[31:0];
                  end
                  default: ok = 1'b0;
               endcase
            end
            OP_NEG:    r.result = clamp32(-a, r.fault);
            OP_ASSIGN: r.result = a[31:0];
            OP_MIN:    r.result = (a < b) ? a[31:0] : b[31:0];
            OP_MAX:    r.result = (a > b) ? a[31:0] : b[31:0];
            default:   ok = 1'b0;
         endcase
         if (ok) slot_mirror[dst] = r.result;
         else begin
            r.result = '0;
            r.fault  = FAULT_BAD;
         end
      end else begin
         r.fault = FAULT_BAD;
      end
      return r;
   endfunction

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [OP_W-1:0] op,
                            input logic [ADDR_W-1:0] sa, input logic [ADDR_W-1:0] sb,
                            input logic [ADDR_W-1:0] dst, input logic signed [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_opcode <= op;
      req_src_a  <= sa;
      req_src_b  <= sb;
      req_dest   <= dst;
      req_value  <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.push_back(execute_model(kind, op, sa, sb, dst, val));
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_item_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected transaction result %h fault %0d", $time,
                     rsp_result, rsp_fault);
            err_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_result !== exp_rsp.result) begin
               $display("%0t: result expected %h actual %h", $time, exp_rsp.result,
                        rsp_result);
               err_count++;
            end
            if (rsp_fault !== exp_rsp.fault) begin
               $display("%0t: fault expected %0d actual %0d", $time, exp_rsp.fault,
                        rsp_fault);
               err_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return MAXV;
         1: return MINV;
         2: return 32'(int'($urandom_range(131072)) - 65536);
         3: return 32'(int'($urandom_range(1310720)) - 655360);
         4: return '0;
         5: return $urandom_range(1) ? -ONE_Q16 : ONE_Q16;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ADDR_W-1:0] pick_slot();
      return $urandom_range(3) == 0 ? ADDR_W'($urandom_range(255)) :
                                      ADDR_W'($urandom_range(15));
   endfunction

   task automatic test_writes_and_reads();
      send_item(KIND_READ, OP_ADD, 8'd7, 8'd0, 8'd0, 32'sd0);
      send_item(KIND_WRITE, OP_ADD, 8'd0, 8'd0, 8'd0, MAXV);
      send_item(KIND_WRITE, OP_ADD, 8'd0, 8'd0, 8'd1, MINV);
      send_item(KIND_WRITE, OP_ADD, 8'd0, 8'd0, 8'd255, 32'sd65536);
      send_item(KIND_WRITE, OP_ADD, 8'd0, 8'd0, 8'd2, 32'sd0);
      send_item(KIND_READ, OP_ADD, 8'd255, 8'd0, 8'd0, 32'sd0);
      send_item(KIND_NONE, OP_ADD, 8'd0, 8'd0, 8'd3, 32'sd5);
   endtask

   task automatic test_all_opcodes();
      for (int op = 0; op < 16; op++)
         send_item(KIND_EXEC, OP_W'(op), 8'd0, 8'd1, 8'd10, 32'sd0);
      send_item(KIND_EXEC, OP_DIV, 8'd0, 8'd2, 8'd11, 32'sd0);
      send_item(KIND_EXEC, OP_REM, 8'd1, 8'd2, 8'd11, 32'sd0);
      send_item(KIND_EXEC, OP_NEG, 8'd1, 8'd0, 8'd11, 32'sd0);
      send_item(KIND_EXEC, OP_MUL, 8'd1, 8'd1, 8'd11, 32'sd0);
   endtask

   task automatic test_functions();
      send_item(KIND_WRITE, OP_ADD, 8'd0, 8'd0, 8'd20, 32'sd102944);
      for (int fn = 0; fn < 7; fn++)
         send_item(KIND_EXEC, OP_FUNC, ADDR_W'(fn), 8'd20, 8'd21, 32'sd0);
      send_item(KIND_EXEC, OP_FUNC, FN_TAN, 8'd2, 8'd21, 32'sd0);
      send_item(KIND_EXEC, OP_FUNC, 8'd255, 8'd1, 8'd21, 32'sd0);
   endtask

   task automatic test_random_items(input int count);
      logic [KIND_W-1:0] kind;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] sa;
      int                sel;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         kind = sel < 28 ? KIND_WRITE : sel < 36 ? KIND_READ : sel < 38 ? KIND_NONE : KIND_EXEC;
         op = $urandom_range(19) == 0 ? OP_W'($urandom_range(15)) : OP_W'($urandom_range(9));
         sa = pick_slot();
         if (kind == KIND_EXEC && op == OP_FUNC && $urandom_range(7) != 0)
            sa = ADDR_W'($urandom_range(5));
         send_item(kind, op, sa, pick_slot(), pick_slot(), pick_value());
      end
   endtask

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= '0;
      req_opcode <= '0;
      req_src_a <= '0;
      req_src_b <= '0;
      req_dest <= '0;
      req_value <= '0;
      rsp_stall <= 1'b0;
      err_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_mirror[i] = '0;
      for (int i = 0; i < TRIG_STEPS; i++) atan_tbl[i] = arctan_turns(i);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_writes_and_reads();
      test_all_opcodes();
      test_functions();
      go_idle();
      test_random_items(270);
      send_idle_pct = 47;
      test_random_items(270);
      send_idle_pct = 0;
      rsp_stall_pct = 47;
      test_random_items(270);
      send_idle_pct = 37;
      rsp_stall_pct = 37;
      test_random_items(270);
      go_idle();
      repeat (100) @(posedge clock);
      if (err_count == 0 && expected_rsps.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
